// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VTPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtpd assertion failed");

// Next-cycle implication, checked out of reset.
`define VTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtpd assertion failed");

`endif

// ===== rtl/core/vtpd_pkg.sv =====
// Types and constants for the vertex transform and perspective divide pipeline.
package vtpd_pkg;

    localparam int COORD_W     = 32;
    localparam int COEF_W      = 16;
    localparam int ROW_W       = 64;
    localparam int QUO_BITS    = 33;
    localparam int CFG_INDEX_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        MVP_ROW0 = 4'd0,
        MVP_ROW1 = 4'd1,
        MVP_ROW2 = 4'd2,
        MVP_ROW3 = 4'd3,
        NRM_ROW0 = 4'd4,
        NRM_ROW1 = 4'd5,
        NRM_ROW2 = 4'd6,
        NRM_ROW3 = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pos_w;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
    } vtx_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ndc_x;
        logic signed [COORD_W-1:0] ndc_y;
        logic signed [COORD_W-1:0] ndc_z;
        logic signed [COORD_W-1:0] out_normal_x;
        logic signed [COORD_W-1:0] out_normal_y;
        logic signed [COORD_W-1:0] out_normal_z;
        logic                      w_was_zero;
        logic                      saturated;
    } vtx_out_t;

endpackage

// ===== rtl/core/vertex_transform_perspective_divide.sv =====
// Pipeline: 38 register stages (product, sum, prep, 34 divider stages, output).
// Throughput: one vertex per cycle while the result is not stalled; bubbles
// collapse, so a stalled result does not block accepts while stages are empty.
// The 34-stage restoring divider (33 quotient bits) sets the depth.
// Reset clears all valid bits and loads identity into both matrices.
`include "assert_macros.svh"

module vertex_transform_perspective_divide
    import vtpd_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS  = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vtx_valid,
    output logic                   vtx_stall,
    input  vtx_in_t                vtx,
    output logic                   res_valid,
    input  logic                   res_stall,
    output vtx_out_t               res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]       cfg_data
);

    localparam int TW     = 51 - COEF_FRAC_BITS;
    localparam int DIV_S  = QUO_BITS + 1;
    localparam int DIV0   = 3;
    localparam int L      = DIV0 + DIV_S + 1;
    localparam int EPS_RAW = ((1 << COORD_FRAC_BITS) + 5000) / 10000;
    localparam int EPS    = (EPS_RAW > 0) ? EPS_RAW : 1;

    typedef struct packed {
        logic                           wz;
        logic                           nsat;
        logic [2:0][COORD_W-1:0]        nval;
    } side_t;

    // configuration
    logic [3:0][ROW_W-1:0] mvp_row_reg;
    logic [3:0][ROW_W-1:0] nrm_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mvp_row_reg[i] <= ROW_W'(1) << (COEF_FRAC_BITS + 16 * i);
                nrm_row_reg[i] <= ROW_W'(1) << (COEF_FRAC_BITS + 16 * i);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                MVP_ROW0: mvp_row_reg[0] <= cfg_data;
                MVP_ROW1: mvp_row_reg[1] <= cfg_data;
                MVP_ROW2: mvp_row_reg[2] <= cfg_data;
                MVP_ROW3: mvp_row_reg[3] <= cfg_data;
                NRM_ROW0: nrm_row_reg[0] <= cfg_data;
                NRM_ROW1: nrm_row_reg[1] <= cfg_data;
                NRM_ROW2: nrm_row_reg[2] <= cfg_data;
                NRM_ROW3: nrm_row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance
    logic [L-1:0] v_reg;
    logic [L-1:0] adv;

    assign adv[L-1] = !v_reg[L-1] || !res_stall;
    for (genvar i = 0; i < L - 1; i++)
    begin : g_adv
        assign adv[i] = !v_reg[i] || adv[i+1];
    end

    assign vtx_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= vtx_valid;
            end
            for (int i = 1; i < L; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stages 0-1: transform
    logic signed [3:0][TW-1:0] pos_t;
    logic signed [2:0][TW-1:0] nrm_t;

    vtpd_xform #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_xform (
        .clk      (clk),
        .en       (adv[1:0]),
        .vtx      (vtx),
        .mvp_rows (mvp_row_reg),
        .nrm_rows (nrm_row_reg),
        .pos_t    (pos_t),
        .nrm_t    (nrm_t)
    );

    // stage 2: zero-w replacement, magnitudes, normal clamp
    logic signed [TW-1:0] wv;
    logic                 wz;
    side_t                side_next;
    logic [TW-1:0]        mag_next [3];
    logic                 neg_next [3];
    logic [TW-1:0]        den_next;

    always_comb
    begin
        wz        = (pos_t[3] == '0);
        wv        = wz ? TW'(EPS) : pos_t[3];
        den_next  = wv[TW-1] ? TW'(-wv) : TW'(wv);
        side_next.wz   = wz;
        side_next.nsat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = pos_t[i][TW-1] ? TW'(-pos_t[i]) : TW'(pos_t[i]);
            neg_next[i] = pos_t[i][TW-1] ^ wv[TW-1];
            if ((&nrm_t[i][TW-1:COORD_W-1]) || !(|nrm_t[i][TW-1:COORD_W-1]))
            begin
                side_next.nval[i] = nrm_t[i][COORD_W-1:0];
            end
            else
            begin
                side_next.nsat    = 1'b1;
                side_next.nval[i] = nrm_t[i][TW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
    end

    logic [TW-1:0] mag_reg [3];
    logic          neg_reg [3];
    logic [TW-1:0] den_reg;
    side_t         side_reg [DIV_S+1];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_next[i];
                neg_reg[i] <= neg_next[i];
            end
            den_reg     <= den_next;
            side_reg[0] <= side_next;
        end
        for (int s = 1; s <= DIV_S; s++)
        begin
            if (adv[DIV0 + s - 1])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // stages 3..36: dividers
    logic [QUO_BITS-1:0] quo  [3];
    logic                ovf  [3];
    logic                qneg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vtpd_div #(
            .MAG_W (TW),
            .FRAC  (COORD_FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (adv[DIV0 + DIV_S - 1:DIV0]),
            .num     (mag_reg[i]),
            .den     (den_reg),
            .neg     (neg_reg[i]),
            .quo     (quo[i]),
            .ovf     (ovf[i]),
            .neg_out (qneg[i])
        );
    end

    // output stage: saturate and sign
    vtx_out_t            res_next;
    vtx_out_t            res_reg;
    logic [QUO_BITS-1:0] lim  [3];
    logic [QUO_BITS-1:0] qmag [3];
    logic                qsat [3];
    logic [COORD_W-1:0]  qval [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lim[i]  = qneg[i] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            qsat[i] = ovf[i] || (quo[i] > lim[i]);
            qmag[i] = qsat[i] ? lim[i] : quo[i];
            qval[i] = qneg[i] ? COORD_W'(-qmag[i]) : qmag[i][COORD_W-1:0];
        end
        res_next.ndc_x        = qval[0];
        res_next.ndc_y        = qval[1];
        res_next.ndc_z        = qval[2];
        res_next.out_normal_x = side_reg[DIV_S].nval[0];
        res_next.out_normal_y = side_reg[DIV_S].nval[1];
        res_next.out_normal_z = side_reg[DIV_S].nval[2];
        res_next.w_was_zero   = side_reg[DIV_S].wz;
        res_next.saturated    = side_reg[DIV_S].nsat || qsat[0] || qsat[1] || qsat[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[L-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = v_reg[L-1];

    // an empty output stage means every stage can move
    `VTPD_ASSERT_NOW(a_no_stall_when_drained, clk, rst_n, !v_reg[L-1], !vtx_stall)
    `VTPD_ASSERT_NEXT(a_accept_fills_first, clk, rst_n, vtx_valid && !vtx_stall, v_reg[0])
    `VTPD_ASSERT_NEXT(a_held_result_kept, clk, rst_n, res_valid && res_stall, res_valid)

endmodule

// ===== rtl/core/vtpd_xform.sv =====
// Matrix-vector front end: product stage, then rounded row sums.
module vtpd_xform
    import vtpd_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS  = 12
)
(
    input  logic                                   clk,
    input  logic [1:0]                             en,
    input  vtx_in_t                                vtx,
    input  logic [3:0][ROW_W-1:0]                  mvp_rows,
    input  logic [3:0][ROW_W-1:0]                  nrm_rows,
    output logic signed [3:0][51-COEF_FRAC_BITS-1:0] pos_t,
    output logic signed [2:0][51-COEF_FRAC_BITS-1:0] nrm_t
);

    localparam int PW = COORD_W + COEF_W;
    localparam int AW = PW + 3;
    localparam int TW = AW - COEF_FRAC_BITS;

    logic signed [PW-1:0] pprod_reg [4][4];
    logic signed [PW-1:0] nprod_reg [3][4];
    logic signed [TW-1:0] pos_t_reg [4];
    logic signed [TW-1:0] nrm_t_reg [3];

    logic signed [COORD_W-1:0] pv [4];
    logic signed [COORD_W-1:0] nv [3];

    assign pv[0] = vtx.pos_x;
    assign pv[1] = vtx.pos_y;
    assign pv[2] = vtx.pos_z;
    assign pv[3] = vtx.pos_w;
    assign nv[0] = vtx.normal_x;
    assign nv[1] = vtx.normal_y;
    assign nv[2] = vtx.normal_z;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pprod_reg[r][j] <= PW'($signed(mvp_rows[r][16*j +: 16])) * PW'(pv[j]);
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    nprod_reg[r][j] <= PW'($signed(nrm_rows[r][16*j +: 16])) * PW'(nv[j]);
                end
                // fourth normal component is 1.0
                nprod_reg[r][3] <= PW'($signed(nrm_rows[r][48 +: 16])) <<< COORD_FRAC_BITS;
            end
        end
    end

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [AW-1:0] pacc [4];
    logic signed [AW-1:0] nacc [3];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            pacc[r] = AW'(pprod_reg[r][0]) + AW'(pprod_reg[r][1]) + AW'(pprod_reg[r][2])
                    + AW'(pprod_reg[r][3]) + HALF;
        end
        for (int r = 0; r < 3; r++)
        begin
            nacc[r] = AW'(nprod_reg[r][0]) + AW'(nprod_reg[r][1]) + AW'(nprod_reg[r][2])
                    + AW'(nprod_reg[r][3]) + HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                pos_t_reg[r] <= pacc[r][AW-1:COEF_FRAC_BITS];
            end
            for (int r = 0; r < 3; r++)
            begin
                nrm_t_reg[r] <= nacc[r][AW-1:COEF_FRAC_BITS];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            pos_t[r] = pos_t_reg[r];
        end
        for (int r = 0; r < 3; r++)
        begin
            nrm_t[r] = nrm_t_reg[r];
        end
    end

endmodule

// ===== rtl/core/vtpd_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, overflow flag up front.
module vtpd_div
    import vtpd_pkg::*;
#(
    parameter int MAG_W = 39,
    parameter int FRAC  = 16
)
(
    input  logic                clk,
    input  logic [QUO_BITS:0]   en,
    input  logic [MAG_W-1:0]    num,
    input  logic [MAG_W-1:0]    den,
    input  logic                neg,
    output logic [QUO_BITS-1:0] quo,
    output logic                ovf,
    output logic                neg_out
);

    localparam int NW = MAG_W + FRAC;

    logic [NW-1:0]       rem_reg [QUO_BITS+1];
    logic [MAG_W-1:0]    d_reg   [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg   [QUO_BITS+1];
    logic                ovf_reg [QUO_BITS+1];
    logic                neg_reg [QUO_BITS+1];

    logic [NW-1:0] num_sh;
    assign num_sh = {num, FRAC'(0)};

    // quotient needs more than QUO_BITS bits: saturate later
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_sh;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_sh >> QUO_BITS) >= NW'(den);
            neg_reg[0] <= neg;
        end
    end

    for (genvar s = 1; s <= QUO_BITS; s++)
    begin : g_step
        localparam int K = QUO_BITS - s;
        logic                ge;
        logic [NW-1:0]       dsh;
        logic [QUO_BITS-1:0] q_next;

        assign dsh    = NW'(d_reg[s-1]) << K;
        assign ge     = (rem_reg[s-1] >> K) >= NW'(d_reg[s-1]);
        // bit K is still clear here, lower bits are filled by later stages
        assign q_next = q_reg[s-1] | (QUO_BITS'(ge) << K);

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]    <= ge ? (rem_reg[s-1] - dsh) : rem_reg[s-1];
                d_reg[s]      <= d_reg[s-1];
                q_reg[s]      <= q_next;
                ovf_reg[s]    <= ovf_reg[s-1];
                neg_reg[s]    <= neg_reg[s-1];
            end
        end
    end

    assign quo     = q_reg[QUO_BITS];
    assign ovf     = ovf_reg[QUO_BITS];
    assign neg_out = neg_reg[QUO_BITS];

endmodule
